// ----- sv/upe_pkg.sv -----
// upe_pkg: shared types and character constants for the percent encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package upe_pkg;

   localparam int unsigned MaxBytes = 7;

   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_FIVE  = 8'h35;

   localparam logic CSR_FORM_STYLE    = 1'b0;
   localparam logic CSR_KEEP_RESERVED = 1'b1;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_PCT   = 2'd1,
      PEND_DIGIT = 2'd2
   } upe_pend_code_type;

   typedef struct packed {
      upe_pend_code_type count;
      logic [7:0]        digit;
   } upe_pend_type;

   typedef struct packed {
      logic form_style;
      logic keep_reserved;
   } upe_cfg_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } upe_item_type;

   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [2:0]               count;
      logic                     last;
   } upe_burst_type;

endpackage
`default_nettype wire

// ----- sv/upe_encode.sv -----
// upe_encode: per-byte encoding logic, builds the output byte sequence
// of one transaction and the next pending-triple state; depends on upe_pkg
`timescale 1ns / 1ps
`default_nettype none
module upe_encode (
   input  upe_pkg::upe_item_type  item,
   input  upe_pkg::upe_pend_type  pend_cur,
   input  upe_pkg::upe_cfg_type   cfg,
   output upe_pkg::upe_burst_type burst,
   output upe_pkg::upe_pend_type  pend_nxt
);
   import upe_pkg::*;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         hex_char = 8'h30 + {4'd0, nib};
      end else begin
         hex_char = 8'h37 + {4'd0, nib};
      end
   endfunction

   logic [7:0]        b;
   logic              b_hex;
   logic              b_alnum;
   logic              b_rsv;
   logic              b_pass;
   logic              do_enc;
   logic [2:0]        n;
   upe_pend_code_type pc;
   logic [7:0]        pd;
   upe_burst_type     seq;

   assign b = item.in_byte;
   assign b_hex = (b inside {["0":"9"], ["A":"F"], ["a":"f"]});
   assign b_alnum = (b inside {["0":"9"], ["A":"Z"], ["a":"z"]});
   assign b_rsv = (b inside {":", "/", "?", "#", "[", "]", "@", "!", "$", "&", "'",
                             "(", ")", "*", "+", ",", ";", "="});

   always_comb begin
      b_pass = b_alnum || (b inside {"-", ".", "_"}) ||
               (cfg.form_style ? (b == CH_STAR) : (b == CH_TILDE));
      if (cfg.keep_reserved && b_rsv &&
          !(cfg.form_style && (b inside {CH_AMP, CH_EQ, CH_PLUS}))) begin
         b_pass = 1'b1;
      end
   end

   always_comb begin
      seq    = '0;
      n      = 3'd0;
      pc     = pend_cur.count;
      pd     = pend_cur.digit;
      do_enc = 1'b0;

      // held prefix: complete, extend or flush a pending triple
      case (pend_cur.count)
         PEND_PCT, PEND_DIGIT: begin
            if (b_hex && pend_cur.count == PEND_PCT) begin
               pc = PEND_DIGIT;
               pd = b;
            end else if (b_hex) begin
               seq.bytes[n] = CH_PCT;
               n = n + 3'd1;
               seq.bytes[n] = pend_cur.digit;
               n = n + 3'd1;
               seq.bytes[n] = b;
               n = n + 3'd1;
               pc = PEND_NONE;
               pd = 8'd0;
            end else begin
               seq.bytes[n] = CH_PCT;
               n = n + 3'd1;
               seq.bytes[n] = CH_TWO;
               n = n + 3'd1;
               seq.bytes[n] = CH_FIVE;
               n = n + 3'd1;
               if (pend_cur.count == PEND_DIGIT) begin
                  seq.bytes[n] = pend_cur.digit;
                  n = n + 3'd1;
               end
               pc     = PEND_NONE;
               pd     = 8'd0;
               do_enc = 1'b1;
            end
         end
         default: begin
            pc     = PEND_NONE;
            do_enc = 1'b1;
         end
      endcase

      // current byte
      if (do_enc) begin
         if (cfg.keep_reserved && b == CH_PCT) begin
            pc = PEND_PCT;
         end else if (cfg.form_style && b == CH_SPACE) begin
            seq.bytes[n] = CH_PLUS;
            n = n + 3'd1;
         end else if (b_pass) begin
            seq.bytes[n] = b;
            n = n + 3'd1;
         end else begin
            seq.bytes[n] = CH_PCT;
            n = n + 3'd1;
            seq.bytes[n] = hex_char(b[7:4]);
            n = n + 3'd1;
            seq.bytes[n] = hex_char(b[3:0]);
            n = n + 3'd1;
         end
      end

      // end of string flushes anything still held
      if (item.in_last && pc != PEND_NONE) begin
         seq.bytes[n] = CH_PCT;
         n = n + 3'd1;
         seq.bytes[n] = CH_TWO;
         n = n + 3'd1;
         seq.bytes[n] = CH_FIVE;
         n = n + 3'd1;
         if (pc == PEND_DIGIT) begin
            seq.bytes[n] = pd;
            n = n + 3'd1;
         end
         pc = PEND_NONE;
         pd = 8'd0;
      end

      seq.count = n;
      seq.last  = item.in_last;
   end

   assign burst          = seq;
   assign pend_nxt.count = pc;
   assign pend_nxt.digit = pd;

endmodule
`default_nettype wire

// ----- sv/upe_serializer.sv -----
// upe_serializer: holds one encoded byte sequence and sends it out one
// byte per cycle, while rsp_ready does not stall it, through the result register; depends on upe_pkg
`timescale 1ns / 1ps
`default_nettype none
module upe_serializer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  upe_pkg::upe_burst_type load_data,
   output logic                   load_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_last
);
   import upe_pkg::*;

   upe_burst_type buf_ff;
   upe_burst_type buf_in;
   logic [2:0]    idx_ff;
   logic [2:0]    idx_in;
   logic          busy_ff;
   logic          busy_in;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_last_ff;
   logic          out_load;
   logic          pop;
   logic          at_end;
   logic          final_pop;

   assign out_load   = !rsp_valid_ff || rsp_ready;
   assign pop        = busy_ff && out_load;
   assign at_end     = (idx_ff == buf_ff.count - 3'd1);
   assign final_pop  = pop && at_end;
   assign load_ready = !busy_ff || final_pop;

   always_comb begin
      buf_in  = buf_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (load) begin
         buf_in  = load_data;
         idx_in  = 3'd0;
         busy_in = 1'b1;
      end else if (final_pop) begin
         busy_in = 1'b0;
      end else if (pop) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         if (out_load) begin
            rsp_valid_ff <= pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (pop) begin
         rsp_byte_ff <= buf_ff.bytes[idx_ff];
         rsp_last_ff <= buf_ff.last && at_end;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule
`default_nettype wire

// ----- sv/url_percent_encoder_core.sv -----
// url_percent_encoder_core: streaming percent encoder, top level
// path: input transaction register, serializer buffer, then result register
// throughput: one transaction per cycle when it gives 0 or 1 bytes, otherwise
//   one result byte per cycle (3 for an escaped byte, up to 7) while rsp_ready
//   does not stall, set by the one-byte result register
// reset: synchronous, clears pending triple state, mode registers and all valids
`timescale 1ns / 1ps
`default_nettype none
module url_percent_encoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic       csr_wdata
);
   import upe_pkg::*;

   logic          in_valid_ff;
   upe_item_type  item_ff;
   upe_pend_type  pend_ff;
   upe_pend_type  pend_in;
   upe_cfg_type   cfg_ff;
   upe_burst_type burst;
   logic          burst_ready;
   logic          in_take;
   logic          burst_load;

   assign in_take    = in_valid_ff && burst_ready;
   assign burst_load = in_take && (burst.count != 3'd0);
   assign req_ready  = !in_valid_ff || in_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         pend_ff.count       <= PEND_NONE;
         pend_ff.digit       <= 8'd0;
         cfg_ff.form_style    <= 1'b0;
         cfg_ff.keep_reserved <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (in_take) begin
            pend_ff <= pend_in;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_FORM_STYLE:    cfg_ff.form_style    <= csr_wdata;
               CSR_KEEP_RESERVED: cfg_ff.keep_reserved <= csr_wdata;
               default:           cfg_ff <= cfg_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.in_byte <= req_in_byte;
         item_ff.in_last <= req_in_last;
      end
   end

   upe_encode u_encode (
      .item     (item_ff),
      .pend_cur (pend_ff),
      .cfg      (cfg_ff),
      .burst    (burst),
      .pend_nxt (pend_in)
   );

   upe_serializer u_serializer (
      .clock        (clock),
      .reset        (reset),
      .load         (burst_load),
      .load_data    (burst),
      .load_ready   (burst_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule
`default_nettype wire

// ----- sv/upe_checker.sv -----
// upe_checker: port-level checks for url_percent_encoder_core, bound to it
// depends on upe_pkg and url_percent_encoder_core
`timescale 1ns / 1ps
`default_nettype none
module upe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_in_byte,
   input logic       req_in_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last,
   input logic       csr_we,
   input logic       csr_index,
   input logic       csr_wdata
);
   import upe_pkg::*;

   // stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
                                  $stable(rsp_out_last))
      else $error("stalled rsp transaction changed");

   // reset empties the block
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   // a string never ends on a percent sign
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |-> rsp_out_byte != CH_PCT)
      else $error("string ends with percent");

   // output is plain ascii with no space
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_out_byte[7] && rsp_out_byte != CH_SPACE)
      else $error("unescaped byte on rsp");

endmodule

bind url_percent_encoder_core upe_checker u_upe_checker (.*);
`default_nettype wire
